FILE: src/crypto1_keystream_cipher_top_defines.svh
// Assertion macros shared by the Crypto1 keystream cipher checker.
// No dependencies; included by name from the checker file.
`ifndef CRYPTO1_KEYSTREAM_CIPHER_TOP_DEFINES_SVH
`define CRYPTO1_KEYSTREAM_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, reported through $error
`define CKS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported through $error
`define CKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cks_pkg.sv
// Shared types, constants and filter functions for the Crypto1 keystream cipher.
// No dependencies; used by datapath, controller and top level.
`timescale 1ns / 1ps

package cks_pkg;

   // Operation codes carried by req_operation
   typedef enum logic [1:0] {
      OP_SETUP  = 2'd0,
      OP_AUTH   = 2'd1,
      OP_BYTE   = 2'd2,
      OP_NIBBLE = 2'd3
   } op_type;

   // Register indexes on the csr port
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] REG_SECTOR_KEY = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_CARD_UID   = 2'd1;

   localparam int KeyW  = 48;
   localparam int WordW = 32;
   localparam int HalfW = 24;
   localparam int CntW  = 5;

   // Feedback taps on the even and odd halves
   localparam logic [HalfW-1:0] TapsEven = 24'h2010E1;
   localparam logic [HalfW-1:0] TapsOdd  = 24'h3A7394;

   // Steps minus one for each operation
   localparam logic [CntW-1:0] LastWord   = 5'd31;
   localparam logic [CntW-1:0] LastByte   = 5'd7;
   localparam logic [CntW-1:0] LastNibble = 5'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_RUN    = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic            accept;
      logic            step;
      logic            capture;
      logic [CntW-1:0] bit_idx;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
   } dp_status_type;

   function automatic logic fn_a(input logic [3:0] g);
      fn_a = ((g[0] | g[1]) ^ (g[0] & g[3])) ^ (g[2] & ((g[0] ^ g[1]) | g[3]));
   endfunction

   function automatic logic fn_b(input logic [3:0] g);
      fn_b = ((g[0] & g[1]) | g[2]) ^ ((g[0] ^ g[1]) & (g[2] | g[3]));
   endfunction

   function automatic logic fn_c(input logic [4:0] g);
      fn_c = (g[0] | ((g[1] | g[4]) & (g[3] ^ g[4])))
           ^ ((g[0] ^ (g[1] & g[3])) & ((g[2] ^ g[3]) | (g[1] & g[4])));
   endfunction

   // Keystream bit from the odd half (LFSR bits 9..47 sit at positions 4..23)
   function automatic logic filter_bit(input logic [HalfW-1:0] odd);
      logic [4:0] s;
      s[0] = fn_a(odd[7:4]);
      s[1] = fn_b(odd[11:8]);
      s[2] = fn_b(odd[15:12]);
      s[3] = fn_a(odd[19:16]);
      s[4] = fn_b(odd[23:20]);
      filter_bit = fn_c(s);
   endfunction

endpackage

FILE: src/cks_datapath.sv
// Datapath: config registers, split LFSR, filter, keystream and result register.
// Depends on cks_pkg; driven by cks_controller commands.
`timescale 1ns / 1ps

module cks_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [cks_pkg::CsrIdxW-1:0] csr_index,
   input  logic [cks_pkg::KeyW-1:0]    csr_wdata,
   input  logic [1:0]                  req_operation,
   input  logic [cks_pkg::WordW-1:0]   req_nonce_word,
   input  cks_pkg::dp_cmd_type         cmd,
   output cks_pkg::dp_status_type      status,
   output logic [cks_pkg::WordW-1:0]   rsp_result_word
);

   logic [cks_pkg::KeyW-1:0]  key_ff;
   logic [cks_pkg::WordW-1:0] uid_ff;
   logic [cks_pkg::HalfW-1:0] even_ff, even_in;
   logic [cks_pkg::HalfW-1:0] odd_ff, odd_in;
   logic [cks_pkg::WordW-1:0] feed_ff, feed_in;
   logic [cks_pkg::WordW-1:0] nonce_ff, nonce_in;
   logic [cks_pkg::WordW-1:0] ks_ff, ks_in;
   logic [cks_pkg::WordW-1:0] result_ff, result_in;
   cks_pkg::op_type           op_ff, op_in;
   cks_pkg::op_type           req_op;
   logic [cks_pkg::HalfW-1:0] key_even, key_odd;
   logic                      ks_bit, feed_bit, fb_bit;

   assign req_op = cks_pkg::op_type'(req_operation);

   // Split the key into even and odd LFSR bits
   always_comb begin
      for (int k = 0; k < cks_pkg::HalfW; k++) begin
         key_even[k] = key_ff[2*k];
         key_odd[k]  = key_ff[2*k+1];
      end
   end

   // One LFSR clock: filter output, feed-in and feedback
   always_comb begin
      ks_bit = cks_pkg::filter_bit(odd_ff);
      case (op_ff)
         cks_pkg::OP_SETUP: feed_bit = feed_ff[0];
         cks_pkg::OP_AUTH:  feed_bit = ks_bit ^ feed_ff[0];
         default:           feed_bit = 1'b0;
      endcase
      fb_bit = (^(even_ff & cks_pkg::TapsEven)) ^ (^(odd_ff & cks_pkg::TapsOdd)) ^ feed_bit;
   end

   // Next state of the working registers
   always_comb begin
      even_in  = even_ff;
      odd_in   = odd_ff;
      feed_in  = feed_ff;
      nonce_in = nonce_ff;
      ks_in    = ks_ff;
      op_in    = op_ff;
      if (cmd.accept) begin
         op_in    = req_op;
         nonce_in = req_nonce_word;
         ks_in    = '0;
         if (req_op == cks_pkg::OP_SETUP) begin
            feed_in = uid_ff ^ req_nonce_word;
            even_in = key_even;
            odd_in  = key_odd;
         end else begin
            feed_in = req_nonce_word;
         end
      end else if (cmd.step) begin
         even_in             = odd_ff;
         odd_in              = {fb_bit, even_ff[cks_pkg::HalfW-1:1]};
         feed_in             = {1'b0, feed_ff[cks_pkg::WordW-1:1]};
         ks_in[cmd.bit_idx]  = ks_bit;
      end
   end

   // Result word per operation
   always_comb begin
      result_in = result_ff;
      if (cmd.capture) begin
         case (op_ff)
            cks_pkg::OP_SETUP: result_in = nonce_ff ^ ks_ff;
            cks_pkg::OP_AUTH:  result_in = '0;
            default:           result_in = ks_ff;
         endcase
      end
   end

   // Configuration and LFSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         uid_ff  <= '0;
         even_ff <= '0;
         odd_ff  <= '0;
         op_ff   <= cks_pkg::OP_SETUP;
      end else begin
         if (csr_write && csr_index == cks_pkg::REG_SECTOR_KEY) begin
            key_ff <= csr_wdata;
         end
         if (csr_write && csr_index == cks_pkg::REG_CARD_UID) begin
            uid_ff <= csr_wdata[cks_pkg::WordW-1:0];
         end
         even_ff <= even_in;
         odd_ff  <= odd_in;
         op_ff   <= op_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      feed_ff   <= feed_in;
      nonce_ff  <= nonce_in;
      ks_ff     <= ks_in;
      result_ff <= result_in;
   end

   assign status.op       = op_ff;
   assign rsp_result_word = result_ff;

endmodule

FILE: src/cks_controller.sv
// Controller: accepts an item, counts LFSR steps and hands the result over.
// Depends on cks_pkg; commands cks_datapath.
`timescale 1ns / 1ps

module cks_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cks_pkg::dp_status_type status,
   output cks_pkg::dp_cmd_type    cmd
);

   cks_pkg::state_type        state_ff, state_in;
   logic [cks_pkg::CntW-1:0]  cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [cks_pkg::CntW-1:0]  last_idx;
   logic                      slot_free;

   // Last step index per operation
   always_comb begin
      case (status.op)
         cks_pkg::OP_SETUP,
         cks_pkg::OP_AUTH: last_idx = cks_pkg::LastWord;
         cks_pkg::OP_BYTE: last_idx = cks_pkg::LastByte;
         default:          last_idx = cks_pkg::LastNibble;
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.bit_idx  = cnt_ff;
      case (state_ff)
         cks_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = cks_pkg::ST_RUN;
            end
         end
         cks_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == last_idx) begin
               state_in = cks_pkg::ST_FINISH;
            end
         end
         cks_pkg::ST_FINISH: begin
            if (slot_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cks_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cks_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/crypto1_keystream_cipher_top.sv
// Crypto1 keystream cipher: one item on req_ gives one result word on rsp_.
// An item is accepted, then the single 48-bit LFSR is stepped once a cycle
// (32 steps for setup and auth, 8 for byte, 4 for nibble), then the result
// moves into the output register once that register is free. A new item is
// taken as soon as the result has reached the output register, even while it
// waits for rsp_ready.
// csr_ writes are always taken (index 0 sector key, index 1 card uid, other
// indexes ignored) and are to be issued only while the block is idle.
// Depends on cks_pkg, cks_controller and cks_datapath.
`timescale 1ns / 1ps

module crypto1_keystream_cipher_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [cks_pkg::WordW-1:0]   req_nonce_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cks_pkg::WordW-1:0]   rsp_result_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cks_pkg::CsrIdxW-1:0] csr_index,
   input  logic [cks_pkg::KeyW-1:0]    csr_wdata
);

   cks_pkg::dp_cmd_type    cmd;
   cks_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   cks_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cks_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_operation),
      .req_nonce_word  (req_nonce_word),
      .cmd             (cmd),
      .status          (status),
      .rsp_result_word (rsp_result_word)
   );

endmodule

FILE: src/cks_checker.sv
// Port-level checks for the Crypto1 keystream cipher, bound to the top level.
// Depends on cks_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "crypto1_keystream_cipher_top_defines.svh"

module cks_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cks_pkg::WordW-1:0]   rsp_result_word
);

   // After reset the block is idle with no result pending
   `CKS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid, "not idle after reset")

   // An accepted item keeps the block busy in the next cycle
   `CKS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after transfer")

   // No result can appear in the cycle after a request transfer
   `CKS_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid, "result too early")

   // A stalled result holds its value
   `CKS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_word), "stalled result changed")

endmodule

bind crypto1_keystream_cipher_top cks_checker u_cks_checker (.*);
